/* hdl/quaternion_vector_rotate_unit_defines.svh */
`ifndef QUATERNION_VECTOR_ROTATE_UNIT_DEFINES_SVH
`define QUATERNION_VECTOR_ROTATE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define QVR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("qvr assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define QVR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("qvr assertion failed");

`endif

/* hdl/qvr_pkg.sv */
`default_nettype none
package qvr_pkg;

  localparam int QuoW = 36;  // rotation delta stays below 2^34
  localparam int MagW = 100;
  localparam int C1W  = 65;
  localparam int N2W  = 65;
  localparam int ResW = 39;

  localparam logic signed [31:0] RotMax = 32'sh7fffffff;
  localparam logic signed [31:0] RotMin = 32'sh80000000;

  // Cross product operand selection per component
  localparam int PosQ [3] = '{2, 3, 1};
  localparam int PosC [3] = '{2, 0, 1};
  localparam int NegQ [3] = '{3, 1, 2};
  localparam int NegC [3] = '{1, 2, 0};

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SING = 2'd1,
    ST_SAT  = 2'd2
  } status_e;

  typedef struct packed {
    logic [3:0][31:0] quat;
    logic [2:0][31:0] vec;
    logic             sing;
  } item_t;

  typedef struct packed {
    logic [N2W-1:0]       n2;
    logic [2:0][MagW-1:0] rem;
    logic [2:0][QuoW-1:0] quo;
    logic [2:0]           neg;
    logic [2:0][31:0]     vec;
    logic                 sing;
  } div_t;

endpackage
`default_nettype wire

/* hdl/qvr_front.sv */
`default_nettype none
module qvr_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  output logic               full_o,
  input  wire logic [31:0]   quat_w_i,
  input  wire logic [31:0]   quat_x_i,
  input  wire logic [31:0]   quat_y_i,
  input  wire logic [31:0]   quat_z_i,
  input  wire logic [31:0]   vec_x_i,
  input  wire logic [31:0]   vec_y_i,
  input  wire logic [31:0]   vec_z_i,
  input  wire logic          deq_i,
  output logic               avail_o,
  output qvr_pkg::item_t     item_o
);
  import qvr_pkg::*;

  item_t      mem_q [2];
  item_t      in_item;
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       wr_en, rd_en;

  assign full_o  = (cnt_q == 2'd2);
  assign avail_o = (cnt_q != 2'd0);
  assign wr_en   = push_i && !full_o;
  assign rd_en   = deq_i && avail_o;
  assign item_o  = mem_q[rd_ptr_q];

  // Classify: only the all-zero quaternion is singular
  always_comb begin
    in_item.quat = {quat_z_i, quat_y_i, quat_x_i, quat_w_i};
    in_item.vec  = {vec_z_i, vec_y_i, vec_x_i};
    in_item.sing = ({quat_w_i, quat_x_i, quat_y_i, quat_z_i} == '0);
  end

  always_comb begin
    cnt_d = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 2'd1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_en) wr_ptr_q <= !wr_ptr_q;
      if (rd_en) rd_ptr_q <= !rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_ptr_q] <= in_item;
  end

endmodule
`default_nettype wire

/* hdl/qvr_div_step.sv */
`default_nettype none
module qvr_div_step #(
  parameter int Shift = 0
) (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire qvr_pkg::div_t  d_i,
  output qvr_pkg::div_t       q_o
);
  import qvr_pkg::*;

  localparam int DW = N2W + QuoW;

  div_t          nxt;
  logic [DW-1:0] dsh;
  logic          ge;

  always_comb begin
    nxt = d_i;
    dsh = DW'(d_i.n2) << Shift;
    for (int k = 0; k < 3; k++) begin
      ge = (DW'(d_i.rem[k]) >= dsh);
      if (ge) begin
        nxt.rem[k]        = d_i.rem[k] - dsh[MagW-1:0];
        nxt.quo[k][Shift] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) q_o <= nxt;
  end

endmodule
`default_nettype wire

/* hdl/qvr_back.sv */
`default_nettype none
module qvr_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            avail_i,
  input  wire qvr_pkg::item_t  item_i,
  output logic                 take_o,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output logic signed [31:0]   rot_x_o,
  output logic signed [31:0]   rot_y_o,
  output logic signed [31:0]   rot_z_o,
  output logic [1:0]           status_o
);
  import qvr_pkg::*;

  localparam int NSt = 7 + QuoW + 1;

  logic [NSt-1:0] vld_q;
  logic           en;

  item_t a_q, b_q, c_q, d_q, e_q, f_q;
  logic signed [63:0] b_pc_q [6];
  logic signed [63:0] b_sq_q [4];
  logic signed [C1W-1:0] c_c1_q [3];
  logic [N2W-1:0] c_n2_q, d_n2_q, e_n2_q, f_n2_q;
  logic signed [64:0] d_lo_q [3][3];
  logic signed [64:0] d_hi_q [3][3];
  logic signed [MagW-1:0] e_t_q [3][3];
  logic signed [MagW-1:0] f_t_q [3];
  div_t g_d, dv [QuoW+1];

  logic signed [31:0] rot_q [3];
  logic [1:0]         status_q;

  assign empty_o = !vld_q[NSt-1];
  assign en      = !vld_q[NSt-1] || pop_i;
  assign take_o  = en && avail_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSt-2:0], take_o};
    end
  end

  // First cross product terms and squares of the quaternion
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q <= item_i;
      b_q <= a_q;
      b_pc_q[0] <= $signed(a_q.quat[2]) * $signed(a_q.vec[2]);
      b_pc_q[1] <= $signed(a_q.quat[3]) * $signed(a_q.vec[1]);
      b_pc_q[2] <= $signed(a_q.quat[3]) * $signed(a_q.vec[0]);
      b_pc_q[3] <= $signed(a_q.quat[1]) * $signed(a_q.vec[2]);
      b_pc_q[4] <= $signed(a_q.quat[1]) * $signed(a_q.vec[1]);
      b_pc_q[5] <= $signed(a_q.quat[2]) * $signed(a_q.vec[0]);
      for (int k = 0; k < 4; k++) begin
        b_sq_q[k] <= $signed(a_q.quat[k]) * $signed(a_q.quat[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_q <= b_q;
      for (int k = 0; k < 3; k++) begin
        c_c1_q[k] <= C1W'(b_pc_q[2*k]) - C1W'(b_pc_q[2*k+1]);
      end
      c_n2_q <= N2W'(b_sq_q[0]) + N2W'(b_sq_q[1]) + N2W'(b_sq_q[2]) + N2W'(b_sq_q[3]);
    end
  end

  // Split each C1 into halves so every multiply stays near 32x32
  always_ff @(posedge clk_i) begin
    if (en) begin
      d_q    <= c_q;
      d_n2_q <= c_n2_q;
      for (int k = 0; k < 3; k++) begin
        d_lo_q[k][0] <= $signed(c_q.quat[0]) * $signed({1'b0, c_c1_q[k][31:0]});
        d_hi_q[k][0] <= $signed(c_q.quat[0]) * $signed(c_c1_q[k][64:32]);
        d_lo_q[k][1] <= $signed(c_q.quat[PosQ[k]]) * $signed({1'b0, c_c1_q[PosC[k]][31:0]});
        d_hi_q[k][1] <= $signed(c_q.quat[PosQ[k]]) * $signed(c_c1_q[PosC[k]][64:32]);
        d_lo_q[k][2] <= $signed(c_q.quat[NegQ[k]]) * $signed({1'b0, c_c1_q[NegC[k]][31:0]});
        d_hi_q[k][2] <= $signed(c_q.quat[NegQ[k]]) * $signed(c_c1_q[NegC[k]][64:32]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_q    <= d_q;
      e_n2_q <= d_n2_q;
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          e_t_q[k][j] <= (MagW'(d_hi_q[k][j]) <<< 32) + MagW'(d_lo_q[k][j]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_q    <= e_q;
      f_n2_q <= e_n2_q;
      for (int k = 0; k < 3; k++) begin
        f_t_q[k] <= (e_t_q[k][0] + e_t_q[k][1] - e_t_q[k][2]) <<< 1;
      end
    end
  end

  // Sign and magnitude for the divider
  always_comb begin
    g_d.n2   = f_n2_q;
    g_d.vec  = f_q.vec;
    g_d.sing = f_q.sing;
    g_d.quo  = '0;
    for (int k = 0; k < 3; k++) begin
      g_d.neg[k] = f_t_q[k][MagW-1];
      g_d.rem[k] = g_d.neg[k] ? MagW'(-f_t_q[k]) : MagW'(f_t_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) dv[0] <= g_d;
  end

  for (genvar i = 0; i < QuoW; i++) begin : g_div
    qvr_div_step #(
      .Shift(QuoW - 1 - i)
    ) u_step (
      .clk_i (clk_i),
      .en_i  (en),
      .d_i   (dv[i]),
      .q_o   (dv[i+1])
    );
  end

  // Round half away from zero, add, saturate
  always_ff @(posedge clk_i) begin
    logic [QuoW:0]          mag;
    logic signed [ResW-1:0] res;
    logic                   sat;
    if (en) begin
      sat = 1'b0;
      for (int k = 0; k < 3; k++) begin
        mag = {1'b0, dv[QuoW].quo[k]};
        if ({dv[QuoW].rem[k], 1'b0} >= (MagW+1)'(dv[QuoW].n2)) mag = mag + 1'b1;
        res = ResW'($signed(dv[QuoW].vec[k]));
        if (dv[QuoW].neg[k]) res = res - $signed(ResW'(mag));
        else                 res = res + $signed(ResW'(mag));
        if (dv[QuoW].sing) begin
          rot_q[k] <= '0;
        end else if (res > ResW'(RotMax)) begin
          rot_q[k] <= RotMax;
          sat = 1'b1;
        end else if (res < ResW'(RotMin)) begin
          rot_q[k] <= RotMin;
          sat = 1'b1;
        end else begin
          rot_q[k] <= res[31:0];
        end
      end
      if (dv[QuoW].sing) status_q <= ST_SING;
      else if (sat)      status_q <= ST_SAT;
      else               status_q <= ST_OK;
    end
  end

  assign rot_x_o  = rot_q[0];
  assign rot_y_o  = rot_q[1];
  assign rot_z_o  = rot_q[2];
  assign status_o = status_q;

endmodule
`default_nettype wire

/* hdl/quaternion_vector_rotate_unit.sv */
`default_nettype none
`include "quaternion_vector_rotate_unit_defines.svh"
// Rotates a Q16.16 vector by a Q16.16 quaternion normalized to unit length, one
// request per cycle unless a full output register waits for pop. Requests enter
// a two-entry queue, then a fully pipelined datapath: one input stage, five
// multiply/add stages, a sign/magnitude stage, 36 one-bit restoring divide
// stages (by the squared norm) and a round/saturate output register. The
// divider chain is the longest part of the pipeline; throughput is one request
// per cycle while the output is not stalled. An all-zero quaternion gives a zero
// vector with status 1; a clamped component gives status 2.
module quaternion_vector_rotate_unit (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push,
  output logic              full,
  input  wire logic [31:0]  quat_w_i,
  input  wire logic [31:0]  quat_x_i,
  input  wire logic [31:0]  quat_y_i,
  input  wire logic [31:0]  quat_z_i,
  input  wire logic [31:0]  vec_x_i,
  input  wire logic [31:0]  vec_y_i,
  input  wire logic [31:0]  vec_z_i,
  output logic              empty,
  input  wire logic         pop,
  output logic [31:0]       rot_x_o,
  output logic [31:0]       rot_y_o,
  output logic [31:0]       rot_z_o,
  output logic [1:0]        status_o
);
  import qvr_pkg::*;

  item_t item;
  logic  avail, take;
  logic  rot_at_bound;

  qvr_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .full_o   (full),
    .quat_w_i (quat_w_i),
    .quat_x_i (quat_x_i),
    .quat_y_i (quat_y_i),
    .quat_z_i (quat_z_i),
    .vec_x_i  (vec_x_i),
    .vec_y_i  (vec_y_i),
    .vec_z_i  (vec_z_i),
    .deq_i    (take),
    .avail_o  (avail),
    .item_o   (item)
  );

  qvr_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .avail_i  (avail),
    .item_i   (item),
    .take_o   (take),
    .pop_i    (pop),
    .empty_o  (empty),
    .rot_x_o  (rot_x_o),
    .rot_y_o  (rot_y_o),
    .rot_z_o  (rot_z_o),
    .status_o (status_o)
  );

  assign rot_at_bound = (rot_x_o == RotMax) || (rot_x_o == RotMin) ||
                        (rot_y_o == RotMax) || (rot_y_o == RotMin) ||
                        (rot_z_o == RotMax) || (rot_z_o == RotMin);

  `QVR_ASSERT_IMP(a_sing_zero, !empty && status_o == ST_SING, {rot_x_o, rot_y_o, rot_z_o} == '0)
  `QVR_ASSERT_IMP(a_status_code, !empty, status_o == ST_OK || status_o == ST_SING || status_o == ST_SAT)
  `QVR_ASSERT_IMP(a_sat_bound, !empty && status_o == ST_SAT, rot_at_bound)
  `QVR_ASSERT_NXT(a_queue_drain, !avail && !(push && !full), !full)

endmodule
`default_nettype wire
